// ----- hw/rtl/tsam_pkg.sv -----
// Shared types, constants and helper functions for the time switch alarm matcher.
// No dependencies; every other file of the block except tsam_ram imports this package.
`default_nettype none

package tsam_pkg;

    // Table size and derived widths
    localparam int NUM_ENTRIES = 8;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

    // Results per tick are capped
    localparam int MAX_RES = 16;
    localparam int RES_W   = $clog2(MAX_RES + 1);

    // Field widths
    localparam int TOD_W  = 17;
    localparam int SUM_W  = TOD_W + 1;
    localparam int LOAD_W = 8;
    localparam int MASK_W = 7;
    localparam int DOM_W  = 5;
    localparam int WDAY_W = 3;
    localparam int SLOT_W = 3;
    localparam int OIDX_W = 3;

    // Multiples of one day, for the start + duration wrap
    localparam logic [SUM_W-1:0] DAY1 = SUM_W'(86400);
    localparam logic [SUM_W-1:0] DAY2 = SUM_W'(2 * 86400);
    localparam logic [SUM_W-1:0] DAY3 = SUM_W'(3 * 86400);

    // Item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Day rule of an entry
    typedef enum logic [1:0] {
        MODE_DAILY   = 2'd0,
        MODE_WEEKLY  = 2'd1,
        MODE_MONTHLY = 2'd2,
        MODE_NEVER   = 2'd3
    } t_mode;

    // One schedule entry as stored in the table memory (58 bits)
    typedef struct packed {
        logic              enabled;
        logic [LOAD_W-1:0] load;
        t_mode             mode;
        logic [MASK_W-1:0] mask;
        logic [DOM_W-1:0]  dom;
        logic [TOD_W-1:0]  start;
        logic              use_dur;
        logic [TOD_W-1:0]  stop;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Match result of one entry, handed to the emit stage
    typedef struct packed {
        logic              on;
        logic              off;
        logic [LOAD_W-1:0] load;
        logic [IDX_W-1:0]  idx;
    } t_cand;

    // Status of the emit stage back to the walk control
    typedef struct packed {
        logic adv;       // emit stage takes a new entry this cycle
        logic idle3;     // emit stage holds no entry
        logic fin_done;  // closing word pushed this cycle
    } t_emit_sts;

    // Day rule check against the current weekday and day of month
    function automatic logic f_day_match(input t_entry e,
                                         input logic [WDAY_W-1:0] wday,
                                         input logic [DOM_W-1:0] dom);
        logic [7:0] m;
        logic       hit;
        m = {1'b0, e.mask};  // weekday seven has no mask bit
        unique case (e.mode)
            MODE_DAILY:   hit = 1'b1;
            MODE_WEEKLY:  hit = m[wday];
            MODE_MONTHLY: hit = (e.dom == dom);
            MODE_NEVER:   hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Reduce a sum of two 17-bit times modulo one day (sum stays below four days)
    function automatic logic [TOD_W-1:0] f_mod_day(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] d;
        priority if (s >= DAY3) begin
            d = s - DAY3;
        end else if (s >= DAY2) begin
            d = s - DAY2;
        end else if (s >= DAY1) begin
            d = s - DAY1;
        end else begin
            d = s;
        end
        return d[TOD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tsam_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic                                        i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tsam_match.sv -----
// Match stage: registers one table entry and checks its day rule, start and stop.
// Depends on tsam_pkg.
`default_nettype none

module tsam_match (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_rd_vld,
    input  wire tsam_pkg::t_entry                i_ent,
    input  wire logic                            i_ent_ok,
    input  wire logic [tsam_pkg::IDX_W-1:0]      i_idx,
    input  wire logic [tsam_pkg::TOD_W-1:0]      i_tod,
    input  wire logic [tsam_pkg::WDAY_W-1:0]     i_wday,
    input  wire logic [tsam_pkg::DOM_W-1:0]      i_dom,
    input  wire logic                            i_adv,
    output logic                                 o_take,
    output logic                                 o_v2,
    output tsam_pkg::t_cand                      o_cand
);
    import tsam_pkg::*;

    logic              r_v2;
    logic              r_en;
    logic              r_on_hit;
    logic [SUM_W-1:0]  r_sum;
    logic              r_use_dur;
    logic [TOD_W-1:0]  r_stop;
    logic [LOAD_W-1:0] r_load;
    logic [IDX_W-1:0]  r_idx;
    logic [TOD_W-1:0]  off_t;

    // Stage is free when empty or when its entry moves on
    assign o_take = !r_v2 || i_adv;

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_take) begin
            r_v2 <= i_rd_vld;
        end
    end

    // Day rule, start compare and raw stop sum from the memory word
    always_ff @(posedge i_clk) begin
        if (o_take && i_rd_vld) begin
            r_en      <= i_ent_ok && i_ent.enabled && f_day_match(i_ent, i_wday, i_dom);
            r_on_hit  <= (i_tod == i_ent.start);
            r_sum     <= SUM_W'(i_ent.start) + SUM_W'(i_ent.stop);
            r_use_dur <= i_ent.use_dur;
            r_stop    <= i_ent.stop;
            r_load    <= i_ent.load;
            r_idx     <= i_idx;
        end
    end

    // Stop second: wrapped duration sum or absolute end time
    assign off_t = r_use_dur ? f_mod_day(r_sum) : r_stop;

    assign o_v2        = r_v2;
    assign o_cand.on   = r_en && r_on_hit;
    assign o_cand.off  = r_en && (i_tod == off_t);
    assign o_cand.load = r_load;
    assign o_cand.idx  = r_idx;

endmodule

`default_nettype wire

// ----- hw/rtl/tsam_emit.sv -----
// Emit stage: serializes on/off events, holds back one word to mark the last,
// and drives the output register. Depends on tsam_pkg.
`default_nettype none

module tsam_emit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_v2,
    input  wire tsam_pkg::t_cand                i_cand,
    input  wire logic                           i_fin_req,
    input  wire logic                           i_out_ready,
    output tsam_pkg::t_emit_sts                 o_sts,
    output logic                                o_out_valid,
    output logic                                o_event_valid,
    output logic [tsam_pkg::LOAD_W-1:0]         o_load_id,
    output logic                                o_turn_on,
    output logic [tsam_pkg::OIDX_W-1:0]         o_entry_index,
    output logic                                o_last
);
    import tsam_pkg::*;

    // Stage 3: entry with pending events
    logic              r_v3;
    logic              r_on;
    logic              r_off;
    logic [LOAD_W-1:0] r_load;
    logic [IDX_W-1:0]  r_idx;

    // Held-back event word and count of events this tick
    logic              r_hold_v, n_hold_v;
    logic [LOAD_W-1:0] r_hold_load, n_hold_load;
    logic              r_hold_on, n_hold_on;
    logic [IDX_W-1:0]  r_hold_idx, n_hold_idx;
    logic [RES_W-1:0]  r_n, n_n;

    // Output register
    logic              r_ov, n_ov;
    logic              r_o_ev, n_o_ev;
    logic [LOAD_W-1:0] r_o_load, n_o_load;
    logic              r_o_on, n_o_on;
    logic [OIDX_W-1:0] r_o_idx, n_o_idx;
    logic              r_o_last, n_o_last;

    logic can_push;
    logic create;
    logic step_ok;
    logic any_ev;
    logic both_ev;
    logic step;
    logic adv;
    logic fin_go;

    // Step control: one event per cycle unless the output stalls, on before off
    assign can_push = !r_ov || i_out_ready;
    assign create   = (r_n < RES_W'(MAX_RES));
    assign step_ok  = !create || !r_hold_v || can_push;
    assign any_ev   = r_on || r_off;
    assign both_ev  = r_on && r_off;
    assign step     = r_v3 && any_ev && step_ok;
    assign adv      = !r_v3 || !any_ev || (step_ok && !both_ev);
    assign fin_go   = i_fin_req && !r_v3 && can_push;

    assign o_sts.adv      = adv;
    assign o_sts.idle3    = !r_v3;
    assign o_sts.fin_done = fin_go;

    // Stage 3 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3  <= 1'b0;
            r_on  <= 1'b0;
            r_off <= 1'b0;
        end else if (adv) begin
            r_v3  <= i_v2;
            r_on  <= i_v2 && i_cand.on;
            r_off <= i_v2 && i_cand.off;
        end else if (step) begin
            if (r_on) begin
                r_on <= 1'b0;
            end else begin
                r_off <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_load <= i_cand.load;
            r_idx  <= i_cand.idx;
        end
    end

    // Hold and output next state
    always_comb begin
        n_hold_v    = r_hold_v;
        n_hold_load = r_hold_load;
        n_hold_on   = r_hold_on;
        n_hold_idx  = r_hold_idx;
        n_n         = r_n;
        n_ov        = r_ov && !i_out_ready;
        n_o_ev      = r_o_ev;
        n_o_load    = r_o_load;
        n_o_on      = r_o_on;
        n_o_idx     = r_o_idx;
        n_o_last    = r_o_last;

        // New event replaces the held word, which goes out as not last
        if (step && create) begin
            if (r_hold_v) begin
                n_ov     = 1'b1;
                n_o_ev   = 1'b1;
                n_o_load = r_hold_load;
                n_o_on   = r_hold_on;
                n_o_idx  = OIDX_W'(r_hold_idx);
                n_o_last = 1'b0;
            end
            n_hold_v    = 1'b1;
            n_hold_load = r_load;
            n_hold_on   = r_on;
            n_hold_idx  = r_idx;
            n_n         = r_n + RES_W'(1);
        end

        // Close the tick: held word as last, or an empty word
        if (fin_go) begin
            n_ov     = 1'b1;
            n_o_last = 1'b1;
            if (r_hold_v) begin
                n_o_ev   = 1'b1;
                n_o_load = r_hold_load;
                n_o_on   = r_hold_on;
                n_o_idx  = OIDX_W'(r_hold_idx);
            end else begin
                n_o_ev   = 1'b0;
                n_o_load = '0;
                n_o_on   = 1'b0;
                n_o_idx  = '0;
            end
            n_hold_v = 1'b0;
            n_n      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_n      <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_hold_v <= n_hold_v;
            r_n      <= n_n;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_load <= n_hold_load;
        r_hold_on   <= n_hold_on;
        r_hold_idx  <= n_hold_idx;
        r_o_ev      <= n_o_ev;
        r_o_load    <= n_o_load;
        r_o_on      <= n_o_on;
        r_o_idx     <= n_o_idx;
        r_o_last    <= n_o_last;
    end

    assign o_out_valid   = r_ov;
    assign o_event_valid = r_o_ev;
    assign o_load_id     = r_o_load;
    assign o_turn_on     = r_o_on;
    assign o_entry_index = r_o_idx;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire

// ----- hw/rtl/time_switch_alarm_matcher_unit.sv -----
// Weekly programmable time switch matcher. A write word stores one schedule
// entry in the table memory. A tick word walks the table, reading one entry
// per cycle from the memory while the match stage can take it. Each tick
// yields its events in entry order (on before off for one entry), the last
// one flagged by o_last; a tick with no event yields one word with
// o_event_valid low. Entries never written read as disabled.
// Depends on tsam_pkg, tsam_ram, tsam_match and tsam_emit.
`default_nettype none

module time_switch_alarm_matcher_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_opcode,
    input  wire logic [tsam_pkg::SLOT_W-1:0]    i_slot,
    input  wire logic                           i_enabled,
    input  wire logic [tsam_pkg::LOAD_W-1:0]    i_load_number,
    input  wire logic [1:0]                     i_mode,
    input  wire logic [tsam_pkg::MASK_W-1:0]    i_day_mask,
    input  wire logic [tsam_pkg::DOM_W-1:0]     i_day_of_month,
    input  wire logic [tsam_pkg::TOD_W-1:0]     i_time_of_day,
    input  wire logic                           i_use_duration,
    input  wire logic [tsam_pkg::TOD_W-1:0]     i_stop_time,
    input  wire logic [tsam_pkg::WDAY_W-1:0]    i_weekday,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_event_valid,
    output logic [tsam_pkg::LOAD_W-1:0]         o_load_id,
    output logic                                o_turn_on,
    output logic [tsam_pkg::OIDX_W-1:0]         o_entry_index,
    output logic                                o_last
);
    import tsam_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FINAL = 3'b100
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_ridx;
    logic              r_v1;
    logic              r_ok1;
    logic [IDX_W-1:0]  r_idx1;
    logic [NUM_ENTRIES-1:0] r_vld;
    logic [TOD_W-1:0]  r_tod;
    logic [WDAY_W-1:0] r_wday;
    logic [DOM_W-1:0]  r_dom;

    logic              accept;
    logic              in_range;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    t_entry            wdata;
    logic              walk_more;
    logic              take;
    logic              issue;
    logic [IDX_W-1:0]  raddr;
    logic [ENTRY_W-1:0] rdata;
    logic              v2;
    t_cand             cand;
    t_emit_sts         sts;
    logic              drained;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Table write from a write word
    assign in_range = (6'(i_slot) < 6'(NUM_ENTRIES));
    assign we       = accept && (i_opcode == OP_WRITE) && in_range;
    assign waddr    = IDX_W'(i_slot);

    assign wdata.enabled = i_enabled;
    assign wdata.load    = i_load_number;
    assign wdata.mode    = t_mode'(i_mode);
    assign wdata.mask    = i_day_mask;
    assign wdata.dom     = i_day_of_month;
    assign wdata.start   = i_time_of_day;
    assign wdata.use_dur = i_use_duration;
    assign wdata.stop    = i_stop_time;

    // Walk: one read per cycle while the match stage can take the data
    assign walk_more = (r_state == S_WALK) && (r_ridx != CNT_W'(NUM_ENTRIES));
    assign issue     = walk_more && (!r_v1 || take);
    assign raddr     = r_ridx[IDX_W-1:0];
    assign drained   = !walk_more && !r_v1 && !v2 && sts.idle3;

    tsam_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tsam_match u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_vld (r_v1),
        .i_ent    (t_entry'(rdata)),
        .i_ent_ok (r_ok1),
        .i_idx    (r_idx1),
        .i_tod    (r_tod),
        .i_wday   (r_wday),
        .i_dom    (r_dom),
        .i_adv    (sts.adv),
        .o_take   (take),
        .o_v2     (v2),
        .o_cand   (cand)
    );

    tsam_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_v2          (v2),
        .i_cand        (cand),
        .i_fin_req     (r_state == S_FINAL),
        .i_out_ready   (i_out_ready),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_event_valid (o_event_valid),
        .o_load_id     (o_load_id),
        .o_turn_on     (o_turn_on),
        .o_entry_index (o_entry_index),
        .o_last        (o_last)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ridx  <= '0;
            r_v1    <= 1'b0;
            r_vld   <= '0;
        end else begin
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (issue) begin
                r_v1   <= 1'b1;
                r_ridx <= r_ridx + CNT_W'(1);
            end else if (take) begin
                r_v1 <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_opcode == OP_TICK)) begin
                        r_ridx  <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (drained) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    if (sts.fin_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Tick fields and read tags
    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == OP_TICK)) begin
            r_tod  <= i_time_of_day;
            r_wday <= i_weekday;
            r_dom  <= i_day_of_month;
        end
        if (issue) begin
            r_idx1 <= raddr;
            r_ok1  <= r_vld[raddr];
        end
    end

    // Checks
    a_notlast_is_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_event_valid)
        else $error("non-last output word carries no event");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && issue))
        else $error("table written while being walked");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!r_v1 && !v2 && sts.idle3))
        else $error("input ready while entries still in flight");

    a_fin_in_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.fin_done |=> (r_state == S_IDLE) && o_out_valid && o_last)
        else $error("closing word not delivered as last");

endmodule

`default_nettype wire
